@@ rtl/tdssd_pkg.sv @@
// Shared types, constants and glyph tables of the three-digit seven-segment driver.
// Has no dependencies; all files but the two interfaces refer to it by scoped names.
package tdssd_pkg;

	// Operation carried by a command word.
	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_CHAR  = 2'd1,
		FUNC_VALUE = 2'd2,
		FUNC_POINT = 2'd3
	} func_t;

	// Class of a string character after decoding.
	typedef enum logic [1:0] {
		CHR_END,
		CHR_GLYPH,
		CHR_POINT,
		CHR_SKIP
	} chr_kind_t;

	// Digit codes and port levels.
	localparam logic [7:0] BlankCode = 8'h20;
	localparam logic [7:0] PointBit  = 8'h80;
	localparam logic [7:0] MinusCode = 8'd16;
	localparam logic [7:0] ECode     = 8'd14;
	localparam logic [7:0] HCode     = 8'd17;
	localparam logic [7:0] ZeroCode  = 8'd0;
	localparam int         Glyphs    = 18;
	localparam int         Digits    = 3;
	localparam logic [1:0] NoPoint   = 2'd3;

	// Character codes recognized in a string.
	localparam logic [7:0] ChrNul   = 8'h00;
	localparam logic [7:0] ChrZero  = 8'h30;
	localparam logic [7:0] ChrNine  = 8'h39;
	localparam logic [7:0] ChrLowA  = 8'h61;
	localparam logic [7:0] ChrLowF  = 8'h66;
	localparam logic [7:0] ChrUpA   = 8'h41;
	localparam logic [7:0] ChrUpF   = 8'h46;
	localparam logic [7:0] ChrMinus = 8'h2D;
	localparam logic [7:0] ChrLowH  = 8'h68;
	localparam logic [7:0] ChrUpH   = 8'h48;
	localparam logic [7:0] ChrSpace = 8'h20;
	localparam logic [7:0] ChrDot   = 8'h2E;
	localparam logic [7:0] LowHexOffset = 8'h57;
	localparam logic [7:0] UpHexOffset  = 8'h37;

	// Segment masks per glyph; a set bit pulls that pin low (lit).
	localparam logic [7:0] SegB [Glyphs] = '{
		8'd48, 8'd0, 8'd16, 8'd16, 8'd32, 8'd48, 8'd48, 8'd16, 8'd48,
		8'd48, 8'd48, 8'd32, 8'd48, 8'd0, 8'd48, 8'd48, 8'd0, 8'd32
	};
	localparam logic [7:0] SegC [Glyphs] = '{
		8'd160, 8'd160, 8'd96, 8'd224, 8'd224, 8'd192, 8'd192, 8'd160, 8'd224,
		8'd224, 8'd224, 8'd192, 8'd0, 8'd224, 8'd64, 8'd64, 8'd64, 8'd192
	};
	localparam logic [7:0] SegD [Glyphs] = '{
		8'd6, 8'd0, 8'd6, 8'd4, 8'd0, 8'd4, 8'd6, 8'd0, 8'd6,
		8'd4, 8'd2, 8'd6, 8'd6, 8'd6, 8'd6, 8'd2, 8'd0, 8'd2
	};

	typedef logic [Digits-1:0][7:0] codes_t;

	// Command word held in the input register.
	typedef struct packed {
		func_t              func;
		logic [7:0]         char_code;
		logic               first_of_string;
		logic signed [10:0] value;
		logic               voltmeter;
		logic [1:0]         position;
	} cmd_t;

	// Decoded string character.
	typedef struct packed {
		chr_kind_t  kind;
		logic [7:0] code;
	} chr_t;

	// Buffer contents produced by an integer command.
	typedef struct packed {
		codes_t codes;
		logic   scan_clr;
	} val_upd_t;

	// Pin levels for one digit.
	typedef struct packed {
		logic [1:0] pb;
		logic [2:0] pc;
		logic [2:0] pd;
	} seg_lvl_t;

	// Result word of a scan tick.
	typedef struct packed {
		logic [2:0] anode;
		seg_lvl_t   lvl;
	} disp_t;

endpackage

@@ rtl/tdssd_cmd_if.sv @@
// Command channel of the three-digit seven-segment driver: valid, ready and one command word.
// Depends on nothing.
interface tdssd_cmd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         func;
	logic [7:0]         char_code;
	logic               first_of_string;
	logic signed [10:0] value;
	logic               voltmeter;
	logic [1:0]         position;

	modport source (output valid, func, char_code, first_of_string, value, voltmeter,
		position, input ready);
	modport sink (input valid, func, char_code, first_of_string, value, voltmeter,
		position, output ready);
endinterface

@@ rtl/tdssd_disp_if.sv @@
// Display channel of the three-digit seven-segment driver: anode select and port levels.
// Depends on nothing.
interface tdssd_disp_if;
	logic       valid;
	logic       ready;
	logic [2:0] anode;
	logic [1:0] port_b_level;
	logic [2:0] port_c_level;
	logic [2:0] port_d_level;

	modport source (output valid, anode, port_b_level, port_c_level, port_d_level,
		input ready);
	modport sink (input valid, anode, port_b_level, port_c_level, port_d_level,
		output ready);
endinterface

@@ rtl/tdssd_char_dec.sv @@
// String character decoder: classifies an ASCII character and gives its digit code.
// Depends on tdssd_pkg.
module tdssd_char_dec (
	input  logic [7:0]      char_code,
	output tdssd_pkg::chr_t chr
);

	// Map the character to a glyph code, a point, the terminator or nothing.
	always_comb begin
		chr.kind = tdssd_pkg::CHR_SKIP;
		chr.code = tdssd_pkg::BlankCode;
		case (char_code) inside
			tdssd_pkg::ChrNul: begin
				chr.kind = tdssd_pkg::CHR_END;
			end
			[tdssd_pkg::ChrZero:tdssd_pkg::ChrNine]: begin
				chr.kind = tdssd_pkg::CHR_GLYPH;
				chr.code = char_code - tdssd_pkg::ChrZero;
			end
			[tdssd_pkg::ChrLowA:tdssd_pkg::ChrLowF]: begin
				chr.kind = tdssd_pkg::CHR_GLYPH;
				chr.code = char_code - tdssd_pkg::LowHexOffset;
			end
			[tdssd_pkg::ChrUpA:tdssd_pkg::ChrUpF]: begin
				chr.kind = tdssd_pkg::CHR_GLYPH;
				chr.code = char_code - tdssd_pkg::UpHexOffset;
			end
			tdssd_pkg::ChrMinus: begin
				chr.kind = tdssd_pkg::CHR_GLYPH;
				chr.code = tdssd_pkg::MinusCode;
			end
			tdssd_pkg::ChrLowH, tdssd_pkg::ChrUpH: begin
				chr.kind = tdssd_pkg::CHR_GLYPH;
				chr.code = tdssd_pkg::HCode;
			end
			tdssd_pkg::ChrSpace: begin
				chr.kind = tdssd_pkg::CHR_GLYPH;
				chr.code = tdssd_pkg::BlankCode;
			end
			tdssd_pkg::ChrDot: begin
				chr.kind = tdssd_pkg::CHR_POINT;
			end
			default: begin
				chr.kind = tdssd_pkg::CHR_SKIP;
			end
		endcase
	end

endmodule

@@ rtl/tdssd_val_conv.sv @@
// Integer to digit-code conversion for the three-digit buffer, with sign and range handling.
// Depends on tdssd_pkg.
module tdssd_val_conv (
	input  logic signed [10:0]   value,
	input  logic                 voltmeter,
	output tdssd_pkg::val_upd_t  upd
);

	logic               neg;
	logic               out_of_range;
	logic               is_zero;
	logic signed [10:0] neg_value;
	logic [9:0]         mag;
	logic [17:0]        prod_tens;
	logic [15:0]        prod_hund;
	logic [6:0]         quot_ten;
	logic [3:0]         hund;
	logic [9:0]         ones_full;
	logic [6:0]         tens_full;
	logic [7:0]         pad;
	logic [7:0]         ones_code;
	logic [7:0]         tens_code;
	logic [7:0]         hund_code;

	// Sign, range and magnitude.
	assign neg          = value[10];
	assign out_of_range = (value < -11'sd99) || (value > 11'sd999);
	assign is_zero      = (value == 11'sd0);
	assign neg_value    = -value;
	assign mag          = neg ? neg_value[9:0] : value[9:0];

	// Division by ten and by a hundred as reciprocal multiplies, exact below one thousand.
	assign prod_tens = 18'(mag) * 18'd205;
	assign prod_hund = 16'(mag) * 16'd41;
	assign quot_ten  = prod_tens[17:11];
	assign hund      = prod_hund[15:12];
	assign ones_full = mag - 10'(quot_ten) * 10'd10;
	assign tens_full = quot_ten - 7'(hund) * 7'd10;
	assign ones_code = {4'd0, ones_full[3:0]};
	assign tens_code = {4'd0, tens_full[3:0]};
	assign hund_code = {4'd0, hund};

	assign pad = voltmeter ? tdssd_pkg::ZeroCode : tdssd_pkg::BlankCode;

	// Show --E out of range, else digits right-aligned, a minus sign left, the voltmeter point.
	always_comb begin
		upd.scan_clr = !is_zero;
		if (out_of_range) begin
			upd.codes[0] = tdssd_pkg::MinusCode;
			upd.codes[1] = tdssd_pkg::MinusCode;
			upd.codes[2] = tdssd_pkg::ECode;
		end else begin
			upd.codes[2] = ones_code;
			if (quot_ten != 7'd0) begin
				upd.codes[1] = tens_code;
			end else if (neg) begin
				upd.codes[1] = tdssd_pkg::MinusCode;
			end else begin
				upd.codes[1] = pad;
			end
			if (hund != 4'd0) begin
				upd.codes[0] = hund_code;
			end else if (neg && quot_ten != 7'd0) begin
				upd.codes[0] = tdssd_pkg::MinusCode;
			end else begin
				upd.codes[0] = pad;
			end
			if (voltmeter && !is_zero) begin
				upd.codes[0] = upd.codes[0] | tdssd_pkg::PointBit;
			end
		end
	end

endmodule

@@ rtl/tdssd_seg_enc.sv @@
// Segment encoder: turns one digit code into the port pin levels (high is dark).
// Depends on tdssd_pkg.
module tdssd_seg_enc (
	input  logic [7:0]          code,
	output tdssd_pkg::seg_lvl_t lvl
);

	logic [6:0] glyph;
	logic       lit;
	logic [4:0] idx;
	logic [7:0] seg_b;
	logic [7:0] seg_c;
	logic [7:0] seg_d;

	assign glyph = code[6:0];
	assign lit   = (glyph < 7'(tdssd_pkg::Glyphs));
	assign idx   = glyph[4:0];

	// Table lookup; codes without a glyph leave every segment dark.
	always_comb begin
		seg_b = 8'd0;
		seg_c = 8'd0;
		seg_d = 8'd0;
		if (lit) begin
			seg_b = tdssd_pkg::SegB[idx];
			seg_c = tdssd_pkg::SegC[idx];
			seg_d = tdssd_pkg::SegD[idx];
		end
	end

	// Lit segments drive their pins low; a set point bit drives the point pin low.
	assign lvl.pb = ~seg_b[5:4];
	assign lvl.pc = ~seg_c[7:5];
	assign lvl.pd = {~code[7], ~seg_d[2:1]};

endmodule

@@ rtl/three_digit_seven_segment_driver_unit.sv @@
// Three-digit multiplexed seven-segment driver. Every command word is registered on acceptance
// and its buffer update is applied when it leaves the input register, so a new word is accepted
// every cycle but while a tick stalls. A scan tick passes the input register and then returns one
// display word from an output register; the only stall comes when a tick meets an output register
// that still holds an untaken display word, and then the input register holds the tick until the
// display side takes it. Strings are right-aligned when the NUL terminator arrives; integers
// outside -99..999 show "--E".
// Depends on tdssd_pkg, tdssd_cmd_if, tdssd_disp_if, tdssd_char_dec, tdssd_val_conv, tdssd_seg_enc.
module three_digit_seven_segment_driver_unit (
	input logic          clk,
	input logic          arst_n,
	tdssd_cmd_if.sink    cmd,
	tdssd_disp_if.source disp
);

	logic                  valid_s1;
	tdssd_pkg::cmd_t       cmd_s1;
	logic                  disp_valid_q;
	tdssd_pkg::disp_t      disp_q;
	tdssd_pkg::codes_t     digit_q;
	logic [1:0]            scan_q;
	logic [7:0]            parse_q [tdssd_pkg::Digits];
	logic [1:0]            count_q;

	logic                  is_tick;
	logic                  out_free;
	logic                  adv;
	tdssd_pkg::chr_t       chr;
	tdssd_pkg::val_upd_t   val_upd;
	tdssd_pkg::seg_lvl_t   lvl;
	logic [1:0]            scan_idx;
	logic [1:0]            scan_nxt;
	logic [7:0]            cur_code;
	tdssd_pkg::codes_t     digit_d;
	logic [1:0]            scan_d;
	logic [1:0]            count_d;
	logic [1:0]            cnt_eff;
	logic [2:0]            parse_we;
	logic [7:0]            parse_wd [tdssd_pkg::Digits];

	// Handshake: the input register moves on unless a tick meets a full output register.
	assign is_tick   = (cmd_s1.func == tdssd_pkg::FUNC_TICK);
	assign out_free  = !disp_valid_q || disp.ready;
	assign adv       = valid_s1 && (!is_tick || out_free);
	assign cmd.ready = !valid_s1 || adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1.func            <= tdssd_pkg::func_t'(cmd.func);
			cmd_s1.char_code       <= cmd.char_code;
			cmd_s1.first_of_string <= cmd.first_of_string;
			cmd_s1.value           <= cmd.value;
			cmd_s1.voltmeter       <= cmd.voltmeter;
			cmd_s1.position        <= cmd.position;
		end
	end

	tdssd_char_dec u_char_dec (
		.char_code (cmd_s1.char_code),
		.chr       (chr)
	);

	tdssd_val_conv u_val_conv (
		.value     (cmd_s1.value),
		.voltmeter (cmd_s1.voltmeter),
		.upd       (val_upd)
	);

	// Scan position and the code of the digit being lit.
	assign scan_idx = (scan_q == 2'd3) ? 2'd0 : scan_q;
	assign scan_nxt = (scan_idx == 2'd2) ? 2'd0 : scan_idx + 2'd1;
	assign cur_code = digit_q[scan_idx];

	tdssd_seg_enc u_seg_enc (
		.code (cur_code),
		.lvl  (lvl)
	);

	// Next buffer, scan and parse state for the word in the input register.
	always_comb begin
		digit_d  = digit_q;
		scan_d   = scan_q;
		count_d  = count_q;
		cnt_eff  = count_q;
		parse_we = 3'b000;
		for (int i = 0; i < tdssd_pkg::Digits; i++) begin
			parse_wd[i] = parse_q[i];
		end
		case (cmd_s1.func)
			tdssd_pkg::FUNC_TICK: begin
				scan_d = scan_nxt;
			end
			tdssd_pkg::FUNC_CHAR: begin
				if (cmd_s1.first_of_string) begin
					digit_d = {tdssd_pkg::Digits{tdssd_pkg::BlankCode}};
					scan_d  = 2'd0;
					cnt_eff = 2'd0;
					count_d = 2'd0;
				end
				if (chr.kind == tdssd_pkg::CHR_END) begin
					// Commit the parsed codes right-aligned, blanks on the left.
					digit_d = {tdssd_pkg::Digits{tdssd_pkg::BlankCode}};
					case (cnt_eff)
						2'd1: begin
							digit_d[2] = parse_q[0];
						end
						2'd2: begin
							digit_d[1] = parse_q[0];
							digit_d[2] = parse_q[1];
						end
						2'd3: begin
							digit_d[0] = parse_q[0];
							digit_d[1] = parse_q[1];
							digit_d[2] = parse_q[2];
						end
						default: begin
							digit_d[2] = tdssd_pkg::BlankCode;
						end
					endcase
					scan_d  = 2'd0;
					count_d = 2'd0;
				end else if (cnt_eff != 2'd3) begin
					if (chr.kind == tdssd_pkg::CHR_GLYPH) begin
						for (int i = 0; i < tdssd_pkg::Digits; i++) begin
							if (2'(i) == cnt_eff) begin
								parse_we[i] = 1'b1;
								parse_wd[i] = chr.code;
							end
						end
						count_d = cnt_eff + 2'd1;
					end else if (chr.kind == tdssd_pkg::CHR_POINT) begin
						if (cnt_eff == 2'd0) begin
							// A leading point makes a blank digit with its point lit.
							parse_we[0] = 1'b1;
							parse_wd[0] = tdssd_pkg::BlankCode | tdssd_pkg::PointBit;
							count_d     = 2'd1;
						end else begin
							for (int i = 0; i < tdssd_pkg::Digits; i++) begin
								if (2'(i) == cnt_eff - 2'd1) begin
									parse_we[i] = 1'b1;
									parse_wd[i] = parse_q[i] | tdssd_pkg::PointBit;
								end
							end
						end
					end
				end
			end
			tdssd_pkg::FUNC_VALUE: begin
				digit_d = val_upd.codes;
				if (val_upd.scan_clr) begin
					scan_d = 2'd0;
				end
			end
			tdssd_pkg::FUNC_POINT: begin
				for (int i = 0; i < tdssd_pkg::Digits; i++) begin
					if (cmd_s1.position != tdssd_pkg::NoPoint && 2'(i) == cmd_s1.position) begin
						digit_d[i] = digit_q[i] | tdssd_pkg::PointBit;
					end
				end
			end
			default: begin
				scan_d = scan_q;
			end
		endcase
	end

	// Buffer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= {tdssd_pkg::Digits{tdssd_pkg::BlankCode}};
			scan_q  <= 2'd0;
			count_q <= 2'd0;
		end else if (adv) begin
			digit_q <= digit_d;
			scan_q  <= scan_d;
			count_q <= count_d;
		end
	end

	// Parse buffer; each entry is read only after it has been written.
	always_ff @(posedge clk) begin
		for (int i = 0; i < tdssd_pkg::Digits; i++) begin
			if (adv && parse_we[i]) begin
				parse_q[i] <= parse_wd[i];
			end
		end
	end

	// Output register for the display word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disp_valid_q <= 1'b0;
		end else if (adv && is_tick) begin
			disp_valid_q <= 1'b1;
		end else if (disp.ready) begin
			disp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && is_tick) begin
			disp_q.anode <= 3'b001 << scan_idx;
			disp_q.lvl   <= lvl;
		end
	end

	assign disp.valid        = disp_valid_q;
	assign disp.anode        = disp_q.anode;
	assign disp.port_b_level = disp_q.lvl.pb;
	assign disp.port_c_level = disp_q.lvl.pc;
	assign disp.port_d_level = disp_q.lvl.pd;

	// The scan never leaves the three digit positions.
	assert property (@(posedge clk) disable iff (!arst_n) scan_q != 2'd3)
		else $error("scan index out of range");

	// A tick leaving the input register always yields a display word next cycle.
	assert property (@(posedge clk) disable iff (!arst_n) (adv && is_tick) |=> disp_valid_q)
		else $error("tick produced no display word");

	// A displayed word selects exactly one digit.
	assert property (@(posedge clk) disable iff (!arst_n) disp_valid_q |-> $onehot(disp_q.anode))
		else $error("anode select not one-hot");

	// A held display word is not overwritten by a non-tick command.
	assert property (@(posedge clk) disable iff (!arst_n)
		(disp_valid_q && !disp.ready && !(adv && is_tick)) |=> $stable(disp_q))
		else $error("held display word changed");

endmodule
